// File: sv/htw_pkg.sv
// shared types and codes of the hierarchical timer wheel
`timescale 1ns / 1ps
`default_nettype none
package htw_pkg;

    // decoded operation of an input item
    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_MOD  = 2'd1,
        OP_DEL  = 2'd2,
        OP_TICK = 2'd3
    } op_t;

    // result status codes
    localparam logic [2:0] ST_ADDED    = 3'd0;
    localparam logic [2:0] ST_MODIFIED = 3'd1;
    localparam logic [2:0] ST_DELETED  = 3'd2;
    localparam logic [2:0] ST_EXPIRED  = 3'd3;
    localparam logic [2:0] ST_IDLE     = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;
    localparam logic [2:0] ST_UNUSED   = 3'd6;

    // classified command from the front to the back
    typedef struct packed {
        op_t                op;
        logic               handle_ok;
        logic [5:0]         handle;
        logic [31:0]        elapse;
        logic signed [31:0] repeat_count;
        logic [31:0]        tag;
    } cmd_t;

    // one result item
    typedef struct packed {
        logic [2:0]         status;
        logic [5:0]         timer_handle;
        logic [31:0]        timer_tag;
        logic signed [31:0] remaining;
        logic [31:0]        tick_now;
        logic               last;
    } res_t;

endpackage
`default_nettype wire

// File: sv/htw_front.sv
// front end: input queue and command classification
`timescale 1ns / 1ps
`default_nettype none
module htw_front #(
    parameter int NUM_TIMERS = 64
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    output logic                full,
    input  wire  [1:0]          kind,
    input  wire  [5:0]          handle,
    input  wire  [31:0]         elapse,
    input  wire  signed [31:0]  repeat_count,
    input  wire  [31:0]         tag,
    input  wire                 busy,
    output logic                cmd_valid,
    output htw_pkg::cmd_t       cmd,
    input  wire                 cmd_pop
);

    localparam int DEPTH = 2;

    htw_pkg::cmd_t q_reg [DEPTH];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    htw_pkg::cmd_t in_cmd;
    logic          acc;

    // classify the incoming item
    always_comb
    begin
        in_cmd.handle       = handle;
        in_cmd.elapse       = elapse;
        in_cmd.repeat_count = repeat_count;
        in_cmd.tag          = tag;
        in_cmd.handle_ok    = ({1'b0, handle} < 7'(NUM_TIMERS));
        in_cmd.op           = htw_pkg::op_t'(kind);
    end

    // queue control
    assign full      = (cnt_reg == 2'(DEPTH)) || busy;
    assign acc       = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (acc)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (cmd_pop && cmd_valid)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        case ({acc, cmd_pop && cmd_valid})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule
`default_nettype wire

// File: sv/htw_outq.sv
// result queue toward the consumer
`timescale 1ns / 1ps
`default_nettype none
module htw_outq (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_push,
    input  htw_pkg::res_t       in_data,
    output logic                in_full,
    output logic                empty,
    input  wire                 pop,
    output htw_pkg::res_t       out_data
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    htw_pkg::res_t q_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign in_full  = (cnt_reg == (PW+1)'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = in_push && !in_full;
    assign do_pop   = pop && !empty;
    assign out_data = q_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule
`default_nettype wire

// File: sv/htw_back.sv
// back end: slot pool, bucket lists and the command and tick sequencer
`timescale 1ns / 1ps
`default_nettype none
module htw_back #(
    parameter int NUM_TIMERS = 64,
    parameter int NEAR_BITS  = 8,
    parameter int FAR_BITS   = 6
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_we,
    input  wire  [31:0]         cfg_wdata,
    input  wire                 cmd_valid,
    input  htw_pkg::cmd_t       cmd,
    output logic                cmd_pop,
    output logic                busy,
    input  wire                 oq_full,
    output logic                oq_push,
    output htw_pkg::res_t       oq_data
);

    localparam int IW        = $clog2(NUM_TIMERS);
    localparam int LW        = IW + 1;
    localparam int NEAR_SIZE = 1 << NEAR_BITS;
    localparam int FAR_SIZE  = 1 << FAR_BITS;
    localparam int NB        = NEAR_SIZE + 4 * FAR_SIZE;
    localparam int BW        = $clog2(NB);
    localparam int NG        = (NUM_TIMERS + 7) / 8;
    localparam int GW        = (NG > 1) ? $clog2(NG) : 1;
    localparam logic [LW-1:0] NIL     = '1;
    localparam logic [63:0]   FMASK64 = 64'(FAR_SIZE - 1);
    localparam logic [63:0]   NMASK64 = 64'(NEAR_SIZE - 1);

    typedef enum logic [19:0] {
        S_CLR      = 20'h00001,
        S_IDLE     = 20'h00002,
        S_ADD_SCAN = 20'h00004,
        S_ADD_WR   = 20'h00008,
        S_UNL_RD   = 20'h00010,
        S_UNL_WR   = 20'h00020,
        S_LT_RD    = 20'h00040,
        S_LT_WR    = 20'h00080,
        S_LT_NX    = 20'h00100,
        S_CAS_HD   = 20'h00200,
        S_CAS_CLR  = 20'h00400,
        S_CAS_RD   = 20'h00800,
        S_CAS_GOT  = 20'h01000,
        S_CAS_DONE = 20'h02000,
        S_NEAR_HD  = 20'h04000,
        S_NEAR_CLR = 20'h08000,
        S_WALK_RD  = 20'h10000,
        S_WALK_GOT = 20'h20000,
        S_NEXT     = 20'h40000,
        S_FIN      = 20'h80000
    } state_t;

    typedef enum logic [1:0] {
        CX_CMD  = 2'd0,
        CX_CAS  = 2'd1,
        CX_WALK = 2'd2
    } ctx_t;

    // bucket for an expiry, filed by its distance from the current tick
    function automatic logic [BW-1:0] pick_bucket(input logic [31:0] e,
                                                  input logic [31:0] now);
        logic [63:0] d;
        logic [63:0] e64;
        logic [63:0] b;
        d   = {32'd0, e - now};
        e64 = {32'd0, e};
        if ((d >> NEAR_BITS) == 64'd0)
            b = e64 & NMASK64;
        else if ((d >> (NEAR_BITS + FAR_BITS)) == 64'd0)
            b = 64'(NEAR_SIZE) + ((e64 >> NEAR_BITS) & FMASK64);
        else if ((d >> (NEAR_BITS + 2 * FAR_BITS)) == 64'd0)
            b = 64'(NEAR_SIZE + FAR_SIZE)
                + ((e64 >> (NEAR_BITS + FAR_BITS)) & FMASK64);
        else if ((d >> (NEAR_BITS + 3 * FAR_BITS)) == 64'd0)
            b = 64'(NEAR_SIZE + 2 * FAR_SIZE)
                + ((e64 >> (NEAR_BITS + 2 * FAR_BITS)) & FMASK64);
        else
            b = 64'(NEAR_SIZE + 3 * FAR_SIZE)
                + ((e64 >> (NEAR_BITS + 3 * FAR_BITS)) & FMASK64);
        return b[BW-1:0];
    endfunction

    // index of the current tick within one far level
    function automatic logic [FAR_BITS-1:0] far_index(input logic [31:0] now,
                                                      input logic [1:0] lvl);
        logic [63:0] v;
        case (lvl)
            2'd0:    v = ({32'd0, now} >> NEAR_BITS) & FMASK64;
            2'd1:    v = ({32'd0, now} >> (NEAR_BITS + FAR_BITS)) & FMASK64;
            2'd2:    v = ({32'd0, now} >> (NEAR_BITS + 2 * FAR_BITS)) & FMASK64;
            default: v = ({32'd0, now} >> (NEAR_BITS + 3 * FAR_BITS)) & FMASK64;
        endcase
        return v[FAR_BITS-1:0];
    endfunction

    // control registers
    state_t                state_reg, state_next;
    ctx_t                  ctx_reg, ctx_next;
    logic [1:0]            lvl_reg, lvl_next;
    logic [31:0]           cur_reg, cur_next;
    logic [NUM_TIMERS-1:0] used_reg, used_next;
    logic                  hv_reg, hv_next;
    logic [BW-1:0]         clr_reg, clr_next;
    logic [GW-1:0]         grp_reg, grp_next;

    // payload registers
    htw_pkg::cmd_t         cmd_reg, cmd_next;
    logic [IW-1:0]         s_reg, s_next;
    logic [LW-1:0]         nx_reg, nx_next;
    logic [31:0]           exp_reg, exp_next;
    logic [BW-1:0]         b_reg, b_next;
    logic [LW-1:0]         t_reg, t_next;
    htw_pkg::res_t         held_reg, held_next;

    // slot memories
    logic [31:0]   exp_mem [NUM_TIMERS];
    logic [31:0]   per_mem [NUM_TIMERS];
    logic [31:0]   rep_mem [NUM_TIMERS];
    logic [31:0]   tag_mem [NUM_TIMERS];
    logic [BW-1:0] bkt_mem [NUM_TIMERS];
    logic [LW-1:0] nxt_mem [NUM_TIMERS];
    logic [LW-1:0] prv_mem [NUM_TIMERS];
    logic [31:0]   exp_rd_reg, per_rd_reg, rep_rd_reg, tag_rd_reg;
    logic [BW-1:0] bkt_rd_reg;
    logic [LW-1:0] nxt_rd_reg, prv_rd_reg;

    // bucket memories
    logic [LW-1:0] hd_mem [NB];
    logic [LW-1:0] tl_mem [NB];
    logic [LW-1:0] hd_rd_reg, tl_rd_reg;

    // memory controls
    logic          s_re;
    logic [IW-1:0] s_raddr;
    logic          b_re;
    logic [BW-1:0] b_raddr;
    logic          exp_we, per_we, rep_we, tag_we, bkt_we;
    logic [31:0]   exp_wd, per_wd, rep_wd, tag_wd;
    logic [BW-1:0] bkt_wd;
    logic          nxt_we, prv_we, hd_we, tl_we;
    logic [IW-1:0] nxt_wa, prv_wa;
    logic [LW-1:0] nxt_wd, prv_wd, hd_wd, tl_wd;
    logic [BW-1:0] hd_wa, tl_wa;

    // helpers
    logic [NG*8-1:0]     used_pad;
    logic [7:0]          grp_used;
    logic                grp_found;
    logic [2:0]          grp_bit;
    logic [BW-1:0]       pick_b;
    logic [FAR_BITS-1:0] fidx;
    logic [BW-1:0]       far_b;
    logic [63:0]         far_b64;
    logic [BW-1:0]       near_b;
    logic [31:0]         rep_dec;
    logic [LW-1:0]       s_link;

    assign pick_b  = pick_bucket(exp_reg, cur_reg);
    assign fidx    = far_index(cur_reg, lvl_reg);
    assign far_b64 = 64'(NEAR_SIZE) + 64'(lvl_reg) * 64'(FAR_SIZE) + 64'(fidx);
    assign far_b   = far_b64[BW-1:0];
    assign near_b  = BW'(cur_reg[NEAR_BITS-1:0]);
    assign rep_dec = rep_rd_reg[31] ? rep_rd_reg : rep_rd_reg - 32'd1;
    assign s_link  = {1'b0, s_reg};
    assign busy    = (state_reg == S_CLR);

    // free slot search, eight slots a cycle
    always_comb
    begin
        used_pad = '1;
        used_pad[NUM_TIMERS-1:0] = used_reg;
        grp_used  = used_pad[grp_reg*8 +: 8];
        grp_found = 1'b0;
        grp_bit   = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (!grp_used[i])
            begin
                grp_found = 1'b1;
                grp_bit   = 3'(i);
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        ctx_next   = ctx_reg;
        lvl_next   = lvl_reg;
        cur_next   = cur_reg;
        used_next  = used_reg;
        hv_next    = hv_reg;
        clr_next   = clr_reg;
        grp_next   = grp_reg;
        cmd_next   = cmd_reg;
        s_next     = s_reg;
        nx_next    = nx_reg;
        exp_next   = exp_reg;
        b_next     = b_reg;
        t_next     = t_reg;
        held_next  = held_reg;

        cmd_pop = 1'b0;
        oq_push = 1'b0;
        oq_data = held_reg;

        s_re    = 1'b0;
        s_raddr = s_reg;
        b_re    = 1'b0;
        b_raddr = b_reg;
        exp_we  = 1'b0;
        exp_wd  = cur_reg + cmd_reg.elapse;
        per_we  = 1'b0;
        per_wd  = cmd_reg.elapse;
        rep_we  = 1'b0;
        rep_wd  = cmd_reg.repeat_count;
        tag_we  = 1'b0;
        tag_wd  = cmd_reg.tag;
        bkt_we  = 1'b0;
        bkt_wd  = b_reg;
        nxt_we  = 1'b0;
        nxt_wa  = s_reg;
        nxt_wd  = NIL;
        prv_we  = 1'b0;
        prv_wa  = s_reg;
        prv_wd  = tl_rd_reg;
        hd_we   = 1'b0;
        hd_wa   = b_reg;
        hd_wd   = NIL;
        tl_we   = 1'b0;
        tl_wa   = b_reg;
        tl_wd   = NIL;

        unique case (state_reg)
            // sweep the bucket lists empty after reset
            S_CLR:
            begin
                hd_we = 1'b1;
                hd_wa = clr_reg;
                tl_we = 1'b1;
                tl_wa = clr_reg;
                if (clr_reg == BW'(NB - 1))
                    state_next = S_IDLE;
                else
                    clr_next = clr_reg + 1'b1;
            end

            // take the next command
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd;
                    ctx_next = CX_CMD;
                    hv_next  = 1'b0;
                    grp_next = '0;
                    lvl_next = 2'd0;
                    s_next   = cmd.handle[IW-1:0];
                    held_next.status       = htw_pkg::ST_UNUSED;
                    held_next.timer_handle = cmd.handle;
                    held_next.timer_tag    = 32'd0;
                    held_next.remaining    = 32'sd0;
                    held_next.tick_now     = cur_reg;
                    held_next.last         = 1'b0;
                    unique case (cmd.op)
                        htw_pkg::OP_ADD:
                            state_next = S_ADD_SCAN;
                        htw_pkg::OP_MOD, htw_pkg::OP_DEL:
                        begin
                            if (cmd.handle_ok && used_reg[cmd.handle[IW-1:0]])
                                state_next = S_UNL_RD;
                            else
                            begin
                                hv_next    = 1'b1;
                                state_next = S_FIN;
                            end
                        end
                        default:
                        begin
                            if (cur_reg[NEAR_BITS-1:0] == '0)
                            begin
                                ctx_next   = CX_CAS;
                                state_next = S_CAS_HD;
                            end
                            else
                                state_next = S_NEAR_HD;
                        end
                    endcase
                end
            end

            // look for the lowest free slot
            S_ADD_SCAN:
            begin
                if (grp_found)
                begin
                    s_next     = IW'({grp_reg, grp_bit});
                    state_next = S_ADD_WR;
                end
                else if (grp_reg == GW'(NG - 1))
                begin
                    held_next.status       = htw_pkg::ST_FULL;
                    held_next.timer_handle = 6'd0;
                    hv_next                = 1'b1;
                    state_next             = S_FIN;
                end
                else
                    grp_next = grp_reg + 1'b1;
            end

            // fill the new slot
            S_ADD_WR:
            begin
                used_next[s_reg] = 1'b1;
                exp_we   = 1'b1;
                per_we   = 1'b1;
                rep_we   = 1'b1;
                tag_we   = 1'b1;
                exp_next = cur_reg + cmd_reg.elapse;
                held_next.status       = htw_pkg::ST_ADDED;
                held_next.timer_handle = 6'(s_reg);
                held_next.timer_tag    = cmd_reg.tag;
                held_next.remaining    = cmd_reg.repeat_count;
                hv_next    = 1'b1;
                state_next = S_LT_RD;
            end

            // read the links of the addressed slot
            S_UNL_RD:
            begin
                s_re       = 1'b1;
                state_next = S_UNL_WR;
            end

            // unlink, then rearm or free
            S_UNL_WR:
            begin
                if (prv_rd_reg[LW-1])
                begin
                    hd_we = 1'b1;
                    hd_wa = bkt_rd_reg;
                    hd_wd = nxt_rd_reg;
                end
                else
                begin
                    nxt_we = 1'b1;
                    nxt_wa = prv_rd_reg[IW-1:0];
                    nxt_wd = nxt_rd_reg;
                end
                if (nxt_rd_reg[LW-1])
                begin
                    tl_we = 1'b1;
                    tl_wa = bkt_rd_reg;
                    tl_wd = prv_rd_reg;
                end
                else
                begin
                    prv_we = 1'b1;
                    prv_wa = nxt_rd_reg[IW-1:0];
                    prv_wd = prv_rd_reg;
                end
                hv_next = 1'b1;
                held_next.timer_handle = 6'(s_reg);
                if (cmd_reg.op == htw_pkg::OP_MOD)
                begin
                    exp_we   = 1'b1;
                    per_we   = 1'b1;
                    rep_we   = 1'b1;
                    tag_we   = (cmd_reg.tag != 32'd0);
                    exp_next = cur_reg + cmd_reg.elapse;
                    held_next.status    = htw_pkg::ST_MODIFIED;
                    held_next.timer_tag = (cmd_reg.tag != 32'd0) ? cmd_reg.tag
                                                                 : tag_rd_reg;
                    held_next.remaining = cmd_reg.repeat_count;
                    state_next = S_LT_RD;
                end
                else
                begin
                    used_next[s_reg]    = 1'b0;
                    held_next.status    = htw_pkg::ST_DELETED;
                    held_next.timer_tag = tag_rd_reg;
                    held_next.remaining = rep_rd_reg;
                    state_next = S_FIN;
                end
            end

            // append to a bucket: read its tail
            S_LT_RD:
            begin
                b_re       = 1'b1;
                b_raddr    = pick_b;
                b_next     = pick_b;
                state_next = S_LT_WR;
            end

            S_LT_WR:
            begin
                nxt_we = 1'b1;
                nxt_wd = NIL;
                prv_we = 1'b1;
                prv_wd = tl_rd_reg;
                bkt_we = 1'b1;
                tl_we  = 1'b1;
                tl_wd  = s_link;
                if (tl_rd_reg[LW-1])
                begin
                    hd_we = 1'b1;
                    hd_wd = s_link;
                end
                t_next = tl_rd_reg;
                if (!tl_rd_reg[LW-1])
                    state_next = S_LT_NX;
                else if (ctx_reg == CX_CMD)
                    state_next = S_FIN;
                else
                    state_next = S_NEXT;
            end

            S_LT_NX:
            begin
                nxt_we = 1'b1;
                nxt_wa = t_reg[IW-1:0];
                nxt_wd = s_link;
                if (ctx_reg == CX_CMD)
                    state_next = S_FIN;
                else
                    state_next = S_NEXT;
            end

            // cascade: take a far bucket whole
            S_CAS_HD:
            begin
                b_re       = 1'b1;
                b_raddr    = far_b;
                b_next     = far_b;
                state_next = S_CAS_CLR;
            end

            S_CAS_CLR:
            begin
                hd_we = 1'b1;
                tl_we = 1'b1;
                if (hd_rd_reg[LW-1])
                    state_next = S_CAS_DONE;
                else
                begin
                    s_next     = hd_rd_reg[IW-1:0];
                    state_next = S_CAS_RD;
                end
            end

            S_CAS_RD:
            begin
                s_re       = 1'b1;
                state_next = S_CAS_GOT;
            end

            S_CAS_GOT:
            begin
                nx_next    = nxt_rd_reg;
                exp_next   = exp_rd_reg;
                state_next = S_LT_RD;
            end

            // next level cascades only when this level's index was zero
            S_CAS_DONE:
            begin
                if (lvl_reg != 2'd3 && fidx == '0)
                begin
                    lvl_next   = lvl_reg + 2'd1;
                    state_next = S_CAS_HD;
                end
                else
                    state_next = S_NEAR_HD;
            end

            // take the current near bucket whole
            S_NEAR_HD:
            begin
                ctx_next   = CX_WALK;
                b_re       = 1'b1;
                b_raddr    = near_b;
                b_next     = near_b;
                state_next = S_NEAR_CLR;
            end

            S_NEAR_CLR:
            begin
                hd_we = 1'b1;
                tl_we = 1'b1;
                if (hd_rd_reg[LW-1])
                    state_next = S_FIN;
                else
                begin
                    s_next     = hd_rd_reg[IW-1:0];
                    state_next = S_WALK_RD;
                end
            end

            S_WALK_RD:
            begin
                s_re       = 1'b1;
                state_next = S_WALK_GOT;
            end

            // fire one timer of the near bucket, or free it when no repeats are left
            S_WALK_GOT:
            begin
                nx_next = nxt_rd_reg;
                if (rep_rd_reg == 32'd0)
                begin
                    used_next[s_reg] = 1'b0;
                    state_next       = S_NEXT;
                end
                else if (!(hv_reg && oq_full))
                begin
                    oq_push      = hv_reg;
                    oq_data      = held_reg;
                    oq_data.last = 1'b0;
                    rep_we = 1'b1;
                    rep_wd = rep_dec;
                    held_next.status       = htw_pkg::ST_EXPIRED;
                    held_next.timer_handle = 6'(s_reg);
                    held_next.timer_tag    = tag_rd_reg;
                    held_next.remaining    = rep_dec;
                    held_next.tick_now     = cur_reg;
                    hv_next = 1'b1;
                    if (rep_dec == 32'd0)
                    begin
                        used_next[s_reg] = 1'b0;
                        state_next       = S_NEXT;
                    end
                    else
                    begin
                        exp_we     = 1'b1;
                        exp_wd     = cur_reg + per_rd_reg;
                        exp_next   = cur_reg + per_rd_reg;
                        state_next = S_LT_RD;
                    end
                end
            end

            // move on along the list being walked
            S_NEXT:
            begin
                s_next = nx_reg[IW-1:0];
                if (ctx_reg == CX_CAS)
                    state_next = nx_reg[LW-1] ? S_CAS_DONE : S_CAS_RD;
                else
                    state_next = nx_reg[LW-1] ? S_FIN : S_WALK_RD;
            end

            // deliver the final result
            S_FIN:
            begin
                if (!oq_full)
                begin
                    oq_push = 1'b1;
                    if (hv_reg)
                        oq_data = held_reg;
                    else
                    begin
                        oq_data.status       = htw_pkg::ST_IDLE;
                        oq_data.timer_handle = 6'd0;
                        oq_data.timer_tag    = 32'd0;
                        oq_data.remaining    = 32'sd0;
                        oq_data.tick_now     = cur_reg;
                    end
                    oq_data.last = 1'b1;
                    if (ctx_reg != CX_CMD)
                        cur_next = cur_reg + 32'd1;
                    state_next = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase

        // start tick load
        if (cfg_we)
            cur_next = cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            ctx_reg   <= CX_CMD;
            lvl_reg   <= 2'd0;
            cur_reg   <= 32'd0;
            used_reg  <= '0;
            hv_reg    <= 1'b0;
            clr_reg   <= '0;
            grp_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ctx_reg   <= ctx_next;
            lvl_reg   <= lvl_next;
            cur_reg   <= cur_next;
            used_reg  <= used_next;
            hv_reg    <= hv_next;
            clr_reg   <= clr_next;
            grp_reg   <= grp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        s_reg    <= s_next;
        nx_reg   <= nx_next;
        exp_reg  <= exp_next;
        b_reg    <= b_next;
        t_reg    <= t_next;
        held_reg <= held_next;
    end

    // slot memories
    always_ff @(posedge clk)
    begin
        if (s_re)
        begin
            exp_rd_reg <= exp_mem[s_raddr];
            per_rd_reg <= per_mem[s_raddr];
            rep_rd_reg <= rep_mem[s_raddr];
            tag_rd_reg <= tag_mem[s_raddr];
            bkt_rd_reg <= bkt_mem[s_raddr];
            nxt_rd_reg <= nxt_mem[s_raddr];
            prv_rd_reg <= prv_mem[s_raddr];
        end
        if (exp_we)
            exp_mem[s_reg] <= exp_wd;
        if (per_we)
            per_mem[s_reg] <= per_wd;
        if (rep_we)
            rep_mem[s_reg] <= rep_wd;
        if (tag_we)
            tag_mem[s_reg] <= tag_wd;
        if (bkt_we)
            bkt_mem[s_reg] <= bkt_wd;
        if (nxt_we)
            nxt_mem[nxt_wa] <= nxt_wd;
        if (prv_we)
            prv_mem[prv_wa] <= prv_wd;
    end

    // bucket memories
    always_ff @(posedge clk)
    begin
        if (b_re)
        begin
            hd_rd_reg <= hd_mem[b_raddr];
            tl_rd_reg <= tl_mem[b_raddr];
        end
        if (hd_we)
            hd_mem[hd_wa] <= hd_wd;
        if (tl_we)
            tl_mem[tl_wa] <= tl_wd;
    end

endmodule
`default_nettype wire

// File: sv/hierarchical_timer_wheel_core.sv
// top level of the five-level hierarchical timer wheel
//
//  channel   handshake        payload
//  input     push / full      kind, handle, elapse, repeat_count, tag
//  result    empty / pop      status, timer_handle, timer_tag, remaining, tick_now, last
//  config    start_tick_we    start_tick_wdata
//
// one item at a time from the front queue; an add searches for a free slot, a tick
// cascades the far levels due, re-files their timers and walks the near bucket;
// a full result queue stalls the back end
// after reset the bucket lists are swept empty, one bucket a cycle:
// 2^NEAR_BITS + 4*2^FAR_BITS buckets (512 by default), full held high.
`timescale 1ns / 1ps
`default_nettype none
module hierarchical_timer_wheel_core #(
    parameter int NUM_TIMERS = 64,
    parameter int NEAR_BITS  = 8,
    parameter int FAR_BITS   = 6
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    output logic                full,
    input  wire  [1:0]          kind,
    input  wire  [5:0]          handle,
    input  wire  [31:0]         elapse,
    input  wire  signed [31:0]  repeat_count,
    input  wire  [31:0]         tag,
    output logic                empty,
    input  wire                 pop,
    output logic [2:0]          status,
    output logic [5:0]          timer_handle,
    output logic [31:0]         timer_tag,
    output logic signed [31:0]  remaining,
    output logic [31:0]         tick_now,
    output logic                last,
    input  wire                 start_tick_we,
    input  wire  [31:0]         start_tick_wdata
);

    logic          busy;
    logic          cmd_valid;
    logic          cmd_pop;
    htw_pkg::cmd_t cmd;
    logic          oq_full;
    logic          oq_push;
    htw_pkg::res_t oq_data;
    htw_pkg::res_t out_data;

    // front: accept and classify
    htw_front #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .kind         (kind),
        .handle       (handle),
        .elapse       (elapse),
        .repeat_count (repeat_count),
        .tag          (tag),
        .busy         (busy),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop)
    );

    // back: wheel state and sequencer
    htw_back #(
        .NUM_TIMERS (NUM_TIMERS),
        .NEAR_BITS  (NEAR_BITS),
        .FAR_BITS   (FAR_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (start_tick_we),
        .cfg_wdata (start_tick_wdata),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .busy      (busy),
        .oq_full   (oq_full),
        .oq_push   (oq_push),
        .oq_data   (oq_data)
    );

    // result queue
    htw_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_push  (oq_push),
        .in_data  (oq_data),
        .in_full  (oq_full),
        .empty    (empty),
        .pop      (pop),
        .out_data (out_data)
    );

    // result fields
    assign status       = out_data.status;
    assign timer_handle = out_data.timer_handle;
    assign timer_tag    = out_data.timer_tag;
    assign remaining    = out_data.remaining;
    assign tick_now     = out_data.tick_now;
    assign last         = out_data.last;

endmodule
`default_nettype wire
